### src/acse_pkg.sv
// Shared constants and codes for the animated cell style effect block.
package acse_pkg;

    localparam int SPAN_MAX_DEF  = 256;
    localparam int ROLES_MAX_DEF = 8;

    localparam int ELAPSED_W  = 32;
    localparam int IDX_W      = 8;
    localparam int LEN_W      = 9;
    localparam int FRAC_W     = 17;
    localparam int KIND_W     = 3;
    localparam int PERIOD_W   = 16;
    localparam int ROLE_W     = 4;
    localparam int SWEEP_W    = 9;
    localparam int SLOT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int FRAC_ONE    = 65536;
    localparam int FRAC_HALF   = 32768;
    localparam int FRAC_SHIFT  = 16;
    localparam int BLINK_STEPS = 2;

    // span / 3 as a reciprocal multiply, exact for spans below 2**19
    localparam int THIRD_DIV   = 3;
    localparam int THIRD_SHIFT = 20;
    localparam int THIRD_MUL   = ((1 << THIRD_SHIFT) + THIRD_DIV - 1) / THIRD_DIV;

    localparam logic [KIND_W-1:0] EFX_BAR      = 3'd0;
    localparam logic [KIND_W-1:0] EFX_PULSE    = 3'd1;
    localparam logic [KIND_W-1:0] EFX_BLINK    = 3'd2;
    localparam logic [KIND_W-1:0] EFX_SHIMMER  = 3'd3;
    localparam logic [KIND_W-1:0] EFX_GRADIENT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_KIND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROLES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP   = 3'd4;

endpackage

### src/animated_cell_style_effect_top.sv
// Top level of the animated cell style effect: config registers, pipeline and output queue.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------------
//  config   | i_cfg_we             | i_cfg_addr, i_cfg_wdata
//  cell in  | i_valid / o_ready    | i_elapsed_ms, i_cell_index, i_span_length,
//           |                      | i_fill_fraction
//  style out| o_valid / i_ready    | o_styled, o_role_slot
//
// One cell enters per clock while o_ready is high. Each result reaches the output queue
// through the four bit-per-stage dividers (time mod period, step, band, slot mod role count)
// and the registers between them. The whole pipeline advances together
// unless the two-entry output queue is full and not being drained; a cell is still taken
// while one result waits. Reset clears valid bits, queue count and config registers.
module animated_cell_style_effect_top
    import acse_pkg::*;
#(
    parameter int SPAN_MAX  = SPAN_MAX_DEF,
    parameter int ROLES_MAX = ROLES_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ELAPSED_W-1:0]  i_elapsed_ms,
    input  logic [IDX_W-1:0]      i_cell_index,
    input  logic [LEN_W-1:0]      i_span_length,
    input  logic [FRAC_W-1:0]     i_fill_fraction,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_styled,
    output logic [SLOT_W-1:0]     o_role_slot
);

    localparam int LW  = $clog2(SPAN_MAX + 1);
    localparam int RW  = $clog2(ROLES_MAX + 1);
    localparam int WW  = (LW > SWEEP_W) ? LW : SWEEP_W;
    localparam int SSW = ((WW + 1) > RW) ? (WW + 1) : RW;
    localparam int BNW = IDX_W + RW;
    localparam int GNW = ((BNW > SSW) ? BNW : SSW) + 1;
    localparam int PNW = PERIOD_W + SSW;
    localparam int FW  = FRAC_W + LW + 1;
    localparam int TW  = LW + THIRD_SHIFT;
    localparam int XW  = (RW > SLOT_W) ? RW : SLOT_W;
    localparam int EW  = SSW + 2;

    typedef struct packed {
        logic [SSW-1:0]   s;
        logic [WW-1:0]    w;
        logic [IDX_W-1:0] idx;
        logic [LW-1:0]    len;
        logic             hit;
        logic [BNW-1:0]   bnum;
        logic [SSW-1:0]   step;
    } t_ctx;

    localparam int CW = $bits(t_ctx);

    logic [KIND_W-1:0]   r_kind;
    logic [PERIOD_W-1:0] r_period;
    logic                r_reverse;
    logic [ROLE_W-1:0]   r_role_count;
    logic [SWEEP_W-1:0]  r_sweep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind       <= EFX_BAR;
            r_period     <= '0;
            r_reverse    <= 1'b0;
            r_role_count <= ROLE_W'(1);
            r_sweep      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_KIND:    r_kind       <= i_cfg_wdata[KIND_W-1:0];
                REG_PERIOD:  r_period     <= i_cfg_wdata[PERIOD_W-1:0];
                REG_REVERSE: r_reverse    <= i_cfg_wdata[0];
                REG_ROLES:   r_role_count <= i_cfg_wdata[ROLE_W-1:0];
                REG_SWEEP:   r_sweep      <= i_cfg_wdata[SWEEP_W-1:0];
                default: ;
            endcase
        end
    end

    logic [RW-1:0] roles_c;
    always_comb begin
        if (r_role_count == '0) begin
            roles_c = RW'(1);
        end else if (32'(r_role_count) > ROLES_MAX) begin
            roles_c = RW'(ROLES_MAX);
        end else begin
            roles_c = RW'(r_role_count);
        end
    end

    logic [1:0] r_cnt;
    logic       en;
    logic       push;
    logic       pop;

    assign en      = (r_cnt != 2'd2) || i_ready;
    assign o_ready = en;

    // stage 0: clamp inputs
    logic                 r0_v;
    logic [ELAPSED_W-1:0] r0_elapsed;
    logic [IDX_W-1:0]     r0_idx;
    logic [LW-1:0]        r0_len;
    logic [FRAC_W-1:0]    r0_frac;
    logic [LW-1:0]        len_c;
    logic [FRAC_W-1:0]    frac_c;

    always_comb begin
        if (i_span_length == '0) begin
            len_c = LW'(1);
        end else if (32'(i_span_length) > SPAN_MAX) begin
            len_c = LW'(SPAN_MAX);
        end else begin
            len_c = LW'(i_span_length);
        end
        frac_c = (32'(i_fill_fraction) > FRAC_ONE) ? FRAC_W'(FRAC_ONE) : i_fill_fraction;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_elapsed <= i_elapsed_ms;
            r0_idx     <= i_cell_index;
            r0_len     <= len_c;
            r0_frac    <= frac_c;
        end
    end

    // stage 1: bar fill, sweep width, band numerator
    logic                 r1_v;
    logic [ELAPSED_W-1:0] r1_elapsed;
    logic [IDX_W-1:0]     r1_idx;
    logic [LW-1:0]        r1_len;
    logic [WW-1:0]        r1_w;
    logic                 r1_hit;
    logic [BNW-1:0]       r1_bnum;
    logic [FW-1:0]        bar_sum;
    logic [TW-1:0]        third_prod;
    logic [LW-1:0]        third;
    logic [WW-1:0]        w_c;

    always_comb begin
        bar_sum    = FW'(r0_frac) * FW'(r0_len) + FW'(FRAC_HALF);
        third_prod = TW'(r0_len) * TW'(THIRD_MUL);
        third      = third_prod[TW-1:THIRD_SHIFT];
        if (r_sweep != '0) begin
            w_c = WW'(r_sweep);
        end else if (third == '0) begin
            w_c = WW'(1);
        end else begin
            w_c = WW'(third);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_elapsed <= r0_elapsed;
            r1_idx     <= r0_idx;
            r1_len     <= r0_len;
            r1_w       <= w_c;
            r1_hit     <= (FW'(r0_idx) < (bar_sum >> FRAC_SHIFT));
            r1_bnum    <= BNW'(r0_idx) * BNW'(roles_c);
        end
    end

    // step count per kind, then elapsed mod period
    t_ctx ctx1;
    always_comb begin
        ctx1      = '0;
        ctx1.w    = r1_w;
        ctx1.idx  = r1_idx;
        ctx1.len  = r1_len;
        ctx1.hit  = r1_hit;
        ctx1.bnum = r1_bnum;
        case (r_kind)
            EFX_PULSE, EFX_GRADIENT: ctx1.s = SSW'(roles_c);
            EFX_BLINK:               ctx1.s = SSW'(BLINK_STEPS);
            EFX_SHIMMER:             ctx1.s = SSW'(r1_len) + SSW'(r1_w);
            default:                 ctx1.s = '0;
        endcase
    end

    logic                d1_v;
    logic [PERIOD_W-1:0] d1_rem;
    logic [CW-1:0]       d1_pl;

    acse_div #(.NW(ELAPSED_W), .DW(PERIOD_W), .PW(CW)) u_div_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_v),
        .i_num   (r1_elapsed),
        .i_den   (r_period),
        .i_pl    (CW'(ctx1)),
        .o_valid (d1_v),
        .o_quo   (),
        .o_rem   (d1_rem),
        .o_pl    (d1_pl)
    );

    // phase * steps
    logic           r3_v;
    logic [PNW-1:0] r3_prod;
    t_ctx           r3_ctx;
    t_ctx           d1_ctx;

    assign d1_ctx = t_ctx'(d1_pl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_prod <= PNW'(d1_rem) * PNW'(d1_ctx.s);
            r3_ctx  <= d1_ctx;
        end
    end

    logic           d2_v;
    logic [PNW-1:0] d2_quo;
    logic [CW-1:0]  d2_pl;

    acse_div #(.NW(PNW), .DW(PERIOD_W), .PW(CW)) u_div_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_num   (r3_prod),
        .i_den   (r_period),
        .i_pl    (CW'(r3_ctx)),
        .o_valid (d2_v),
        .o_quo   (d2_quo),
        .o_rem   (),
        .o_pl    (d2_pl)
    );

    // step with still period and direction applied
    logic           r4_v;
    t_ctx           r4_ctx;
    t_ctx           n4_ctx;
    t_ctx           d2_ctx;
    logic [SSW-1:0] step_i;
    logic [SSW-1:0] step_c;

    always_comb begin
        d2_ctx = t_ctx'(d2_pl);
        step_i = d2_quo[SSW-1:0];
        if ((d2_ctx.s <= SSW'(1)) || (r_period == '0)) begin
            step_c = '0;
        end else if (r_reverse) begin
            step_c = d2_ctx.s - SSW'(1) - step_i;
        end else begin
            step_c = step_i;
        end
        n4_ctx      = d2_ctx;
        n4_ctx.step = step_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ctx <= n4_ctx;
        end
    end

    logic           d3_v;
    logic [BNW-1:0] d3_quo;
    logic [CW-1:0]  d3_pl;

    acse_div #(.NW(BNW), .DW(LW), .PW(CW)) u_div_band (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_num   (r4_ctx.bnum),
        .i_den   (r4_ctx.len),
        .i_pl    (CW'(r4_ctx)),
        .o_valid (d3_v),
        .o_quo   (d3_quo),
        .o_rem   (),
        .o_pl    (d3_pl)
    );

    // band + step
    logic           r5_v;
    logic [GNW-1:0] r5_g;
    t_ctx           r5_ctx;
    t_ctx           d3_ctx;

    assign d3_ctx = t_ctx'(d3_pl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_g   <= GNW'(d3_quo) + GNW'(d3_ctx.step);
            r5_ctx <= d3_ctx;
        end
    end

    logic          d4_v;
    logic [RW-1:0] d4_rem;
    logic [CW-1:0] d4_pl;

    acse_div #(.NW(GNW), .DW(RW), .PW(CW)) u_div_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_num   (r5_g),
        .i_den   (roles_c),
        .i_pl    (CW'(r5_ctx)),
        .o_valid (d4_v),
        .o_quo   (),
        .o_rem   (d4_rem),
        .o_pl    (d4_pl)
    );

    // final decision per kind
    t_ctx              d4_ctx;
    logic [XW-1:0]     grad_slot;
    logic              f_styled;
    logic [SLOT_W-1:0] f_slot;

    always_comb begin
        d4_ctx    = t_ctx'(d4_pl);
        grad_slot = XW'(d4_rem);
        f_styled  = 1'b0;
        f_slot    = '0;
        case (r_kind)
            EFX_BAR: begin
                f_styled = d4_ctx.hit;
            end
            EFX_PULSE: begin
                f_styled = 1'b1;
                f_slot   = d4_ctx.step[SLOT_W-1:0];
            end
            EFX_BLINK: begin
                f_styled = (d4_ctx.step == '0);
            end
            EFX_SHIMMER: begin
                f_styled = (EW'(d4_ctx.idx) <= EW'(d4_ctx.step)) &&
                           ((EW'(d4_ctx.idx) + EW'(d4_ctx.w)) > EW'(d4_ctx.step));
            end
            EFX_GRADIENT: begin
                f_styled = 1'b1;
                f_slot   = grad_slot[SLOT_W-1:0];
            end
            default: ;
        endcase
    end

    // two-entry output queue
    logic              r_q_styled [2];
    logic [SLOT_W-1:0] r_q_slot   [2];
    logic              n_q_styled [2];
    logic [SLOT_W-1:0] n_q_slot   [2];
    logic [1:0]        n_cnt;
    logic [1:0]        wr_pos;

    assign push   = d4_v && en;
    assign pop    = o_valid && i_ready;
    assign wr_pos = r_cnt - {1'b0, pop};
    assign n_cnt  = r_cnt + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        n_q_styled = r_q_styled;
        n_q_slot   = r_q_slot;
        if (pop) begin
            n_q_styled[0] = r_q_styled[1];
            n_q_slot[0]   = r_q_slot[1];
        end
        if (push) begin
            if (wr_pos == 2'd0) begin
                n_q_styled[0] = f_styled;
                n_q_slot[0]   = f_slot;
            end else begin
                n_q_styled[1] = f_styled;
                n_q_slot[1]   = f_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_styled <= n_q_styled;
        r_q_slot   <= n_q_slot;
    end

    assign o_valid     = (r_cnt != 2'd0);
    assign o_styled    = r_q_styled[0];
    assign o_role_slot = r_q_slot[0];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && (r_cnt == 2'd2) && !pop))
        else $error("item pushed into full output queue");

    a_unstyled_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_styled || (o_role_slot == '0)))
        else $error("unstyled item carries a nonzero slot");

    a_blink_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && (r_kind == EFX_BLINK)) |-> (f_slot == '0))
        else $error("blink item carries a nonzero slot");

endmodule

### src/acse_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband payload.
module acse_div #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pl,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [PW-1:0] o_pl
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_quo [NW];
    logic [NW-1:0] r_num [NW];
    logic [DW-1:0] r_den [NW];
    logic [PW-1:0] r_pl  [NW];
    logic          r_v   [NW];

    logic [DW-1:0] rem_in [NW];
    logic [NW-1:0] quo_in [NW];
    logic [NW-1:0] num_in [NW];
    logic [DW-1:0] den_in [NW];
    logic [PW-1:0] pl_in  [NW];
    logic          v_in   [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        localparam int B = NW - 1 - k;
        logic [DW:0]   sh;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [NW-1:0] n_quo;

        if (k == 0) begin : g_first
            assign rem_in[k] = '0;
            assign quo_in[k] = '0;
            assign num_in[k] = i_num;
            assign den_in[k] = i_den;
            assign pl_in[k]  = i_pl;
            assign v_in[k]   = i_valid;
        end else begin : g_next
            assign rem_in[k] = r_rem[k-1];
            assign quo_in[k] = r_quo[k-1];
            assign num_in[k] = r_num[k-1];
            assign den_in[k] = r_den[k-1];
            assign pl_in[k]  = r_pl[k-1];
            assign v_in[k]   = r_v[k-1];
        end

        always_comb begin
            sh    = {rem_in[k], num_in[k][B]};
            diff  = sh - {1'b0, den_in[k]};
            ge    = (sh >= {1'b0, den_in[k]});
            n_rem = ge ? diff[DW-1:0] : sh[DW-1:0];
            n_quo = quo_in[k];
            n_quo[B] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_num[k] <= num_in[k];
                r_den[k] <= den_in[k];
                r_pl[k]  <= pl_in[k];
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_quo[NW-1];
    assign o_rem   = r_rem[NW-1];
    assign o_pl    = r_pl[NW-1];

endmodule

### tb/tb.sv
// Self-checking testbench for the animated cell style effect: directed table, per-kind corner cells, then random cells.
module tb;
    import acse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [ELAPSED_W-1:0] elapsed;
        logic [IDX_W-1:0]     idx;
        logic [LEN_W-1:0]     len;
        logic [FRAC_W-1:0]    frac;
        bit                   typed;
        bit                   exp_styled;
        logic [SLOT_W-1:0]    exp_slot;
    } cell_row_t;

    typedef struct {
        bit                styled;
        logic [SLOT_W-1:0] slot;
    } style_t;

    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [ELAPSED_W-1:0]  i_elapsed_ms = '0;
    logic [IDX_W-1:0]      i_cell_index = '0;
    logic [LEN_W-1:0]      i_span_length = '0;
    logic [FRAC_W-1:0]     i_fill_fraction = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_styled;
    logic [SLOT_W-1:0]     o_role_slot;

    animated_cell_style_effect_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [KIND_W-1:0]   cur_kind;
    logic [PERIOD_W-1:0] cur_period;
    logic                cur_reverse;
    logic [ROLE_W-1:0]   cur_roles;
    logic [SWEEP_W-1:0]  cur_sweep;

    style_t expected_styles[$];
    int     mismatches;
    int     cells_sent;
    int     styles_seen;
    int     cycle_count;

    function automatic longint unsigned step_of(longint unsigned elapsed,
                                                longint unsigned steps);
        longint unsigned i;
        if (steps <= 1 || cur_period == 0) return 0;
        i = ((elapsed % cur_period) * steps) / cur_period;
        if (i >= steps) i = steps - 1;
        return cur_reverse ? steps - 1 - i : i;
    endfunction

    function automatic style_t style_for(cell_row_t c);
        style_t r;
        longint unsigned len, roles, frac, w, pos, band, slot;
        r.styled = 0;
        slot = 0;
        len = c.len;
        roles = cur_roles;
        frac = c.frac;
        if (len == 0) len = 1;
        if (len > SPAN_MAX_DEF) len = SPAN_MAX_DEF;
        if (roles == 0) roles = 1;
        if (roles > ROLES_MAX_DEF) roles = ROLES_MAX_DEF;
        if (frac > FRAC_ONE) frac = FRAC_ONE;
        case (cur_kind)
            EFX_BAR: begin
                if (c.idx < ((frac * len + FRAC_HALF) >> FRAC_SHIFT)) r.styled = 1;
            end
            EFX_PULSE: begin
                r.styled = 1;
                slot = step_of(c.elapsed, roles) % roles;
            end
            EFX_BLINK: begin
                if (step_of(c.elapsed, BLINK_STEPS) == 0) r.styled = 1;
            end
            EFX_SHIMMER: begin
                w = cur_sweep;
                if (w == 0) begin
                    w = len / 3;
                    if (w < 1) w = 1;
                end
                pos = step_of(c.elapsed, len + w);
                if (c.idx <= pos && c.idx + w > pos) r.styled = 1;
            end
            EFX_GRADIENT: begin
                band = c.idx * roles / len;
                r.styled = 1;
                slot = (band + step_of(c.elapsed, roles)) % roles;
            end
            default: ;
        endcase
        r.slot = r.styled ? slot[SLOT_W-1:0] : '0;
        return r;
    endfunction

    task automatic gap(int max_long);
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, max_long)
                                          : $urandom_range(0, 2);
        if (n > 0) i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] a, int unsigned v);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= a;
        i_cfg_wdata <= v[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (a)
            REG_KIND:    cur_kind = v[KIND_W-1:0];
            REG_PERIOD:  cur_period = v[PERIOD_W-1:0];
            REG_REVERSE: cur_reverse = v[0];
            REG_ROLES:   cur_roles = v[ROLE_W-1:0];
            REG_SWEEP:   cur_sweep = v[SWEEP_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain_idle();
        i_valid <= 1'b0;
        while (expected_styles.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_cell(cell_row_t c);
        style_t e;
        e = style_for(c);
        if (c.typed && (e.styled != c.exp_styled || e.slot != c.exp_slot))
            $display("table row disagrees with predictor: cell %0d", c.idx);
        if (c.typed) begin
            e.styled = c.exp_styled;
            e.slot = c.exp_slot;
        end
        i_valid <= 1'b1;
        i_elapsed_ms <= c.elapsed;
        i_cell_index <= c.idx;
        i_span_length <= c.len;
        i_fill_fraction <= c.frac;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_styles.push_back(e);
        cells_sent++;
    endtask

    function automatic cell_row_t row(longint unsigned el, int idx, int len, int frac,
                                      bit typed = 0, bit s = 0, int sl = 0);
        cell_row_t c;
        c.elapsed = ELAPSED_W'(el);
        c.idx = IDX_W'(idx);
        c.len = LEN_W'(len);
        c.frac = FRAC_W'(frac);
        c.typed = typed;
        c.exp_styled = s;
        c.exp_slot = SLOT_W'(sl);
        return c;
    endfunction

    function automatic cell_row_t random_cell();
        cell_row_t c;
        c.elapsed = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200000);
        c.len = LEN_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 511)
                                                   : $urandom_range(1, 256));
        c.idx = IDX_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                       : $urandom_range(0, (c.len > 0 ? c.len - 1 : 0)));
        c.frac = FRAC_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                                     : $urandom_range(0, FRAC_ONE));
        c.typed = 0;
        return c;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($urandom_range(0, 15) == 0) i_ready <= 1'b0;
            else if ($urandom_range(0, 3) != 0) i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        style_t e;
        if (i_rst_n && o_valid && i_ready) begin
            styles_seen++;
            if (expected_styles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected style result");
            end else begin
                e = expected_styles.pop_front();
                if (o_styled !== e.styled || o_role_slot !== e.slot) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: styled %0b slot %0d, expected %0b slot %0d",
                                 o_styled, o_role_slot, e.styled, e.slot);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb NOT OK");
            $finish;
        end
    end

    cell_row_t table_rows[$];
    int unsigned kinds_seen;

    initial begin
        cur_kind = EFX_BAR;
        cur_period = 0;
        cur_reverse = 0;
        cur_roles = 1;
        cur_sweep = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config is a bar with no progress
        table_rows.push_back(row(0, 0, 1, 0, 1, 0, 0));
        table_rows.push_back(row(32'hFFFF_FFFF, 0, 1, FRAC_ONE, 1, 1, 0));
        table_rows.push_back(row(0, 255, 256, FRAC_ONE, 1, 1, 0));
        table_rows.push_back(row(0, 255, 511, 131071, 1, 1, 0));
        table_rows.push_back(row(0, 0, 0, FRAC_HALF, 1, 1, 0));
        table_rows.push_back(row(0, 128, 256, FRAC_HALF, 1, 0, 0));
        table_rows.push_back(row(0, 255, 1, FRAC_ONE, 1, 0, 0));
        foreach (table_rows[i]) begin
            send_cell(table_rows[i]);
            gap(6);
        end
        drain_idle();

        write_reg(REG_PERIOD, 65535);
        write_reg(REG_ROLES, 15);
        write_reg(REG_SWEEP, 511);
        write_reg(REG_REVERSE, 1);
        for (int k = 1; k <= 7; k++) begin
            write_reg(REG_KIND, k);
            send_cell(row(0, 0, 256, 0));
            send_cell(row(32'hFFFF_FFFF, 255, 256, FRAC_ONE));
            send_cell(row(65534, 200, 3, 0));
            drain_idle();
        end
        write_reg(REG_ROLES, 0);
        write_reg(REG_SWEEP, 0);
        write_reg(REG_PERIOD, 0);
        write_reg(REG_KIND, EFX_SHIMMER);
        send_cell(row(12345, 0, 2, 0));
        send_cell(row(12345, 1, 300, 0));
        drain_idle();

        for (int ph = 0; ph < 30; ph++) begin
            int unsigned per;
            per = (ph % 6 == 0) ? 0 : (ph % 6 == 1) ? 65535 : (ph % 6 == 2) ? 1
                : $urandom_range(2, 3000);
            write_reg(REG_KIND, (ph % 8 < 5) ? ph % 5 : $urandom_range(0, 7));
            write_reg(REG_PERIOD, per);
            write_reg(REG_REVERSE, $urandom_range(0, 1));
            write_reg(REG_ROLES, (ph % 4 == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(1, 8));
            write_reg(REG_SWEEP, (ph % 5 == 0) ? $urandom_range(0, 511)
                                                : $urandom_range(0, 20));
            kinds_seen |= 1 << cur_kind;
            for (int n = 0; n < 55; n++) begin
                send_cell(random_cell());
                if (n == 27 && ph == 10) drain_idle();
                else if ($urandom_range(0, 2) == 0) gap(30);
            end
            drain_idle();
        end

        $display("sent %0d cells over 30 random config phases, %0d results checked",
                 cells_sent, styles_seen);
        $display("effect kinds covered mask %0h, mismatches %0d", kinds_seen, mismatches);
        if (mismatches == 0 && expected_styles.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
